[hw/rtl/coc_pkg.sv]
package coc_pkg;

    localparam int NUM_W      = 16;
    localparam int LEN_W      = 16;
    localparam int ERR_W      = 6;
    localparam int PRES_W     = 21;
    localparam int PRES_IDX_W = 5;
    localparam int SINGLE_W   = 13;
    localparam int SINGLE_IDX_W = 4;
    localparam int LEN_MAX_W  = 11;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_VERSION = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_VERSION  = CFG_IDX_W'(1);

    // error bit positions
    localparam int ERR_LEN         = 0;
    localparam int ERR_LEN_CRIT    = 1;
    localparam int ERR_REPEAT      = 2;
    localparam int ERR_REPEAT_CRIT = 3;
    localparam int ERR_UNKNOWN     = 4;
    localparam int ERR_UNKNOWN_CRIT = 5;

    // presence bits of the two programmable options
    localparam logic [PRES_IDX_W-1:0] PRES_CONTENT_VERSION = PRES_IDX_W'(19);
    localparam logic [PRES_IDX_W-1:0] PRES_ACCEPT_VERSION  = PRES_IDX_W'(20);

    localparam int CFG_CONTENT_RESET = 2053;
    localparam int CFG_ACCEPT_RESET  = 2049;

    typedef struct packed {
        logic                    found;
        logic [PRES_IDX_W-1:0]   pres_idx;
        logic                    len_min_one;
        logic [LEN_MAX_W-1:0]    len_max;
        logic                    single;
        logic [SINGLE_IDX_W-1:0] single_idx;
    } rule_t;

    function automatic rule_t mk_rule(input int pidx, input logic min_one, input int lmax,
                                      input logic single, input int sidx);
        rule_t r;
        r.found       = 1'b1;
        r.pres_idx    = PRES_IDX_W'(pidx);
        r.len_min_one = min_one;
        r.len_max     = LEN_MAX_W'(lmax);
        r.single      = single;
        r.single_idx  = SINGLE_IDX_W'(sidx);
        return r;
    endfunction

    // fixed option table, rfc 7252 and friends
    function automatic rule_t lookup_rule(input logic [NUM_W-1:0] num);
        rule_t r;
        r = '0;
        unique case (num)
            NUM_W'(1):  r = mk_rule(0,  1'b0, 8,    1'b0, 0);
            NUM_W'(3):  r = mk_rule(1,  1'b1, 255,  1'b1, 0);
            NUM_W'(4):  r = mk_rule(2,  1'b1, 8,    1'b0, 0);
            NUM_W'(5):  r = mk_rule(3,  1'b0, 0,    1'b1, 1);
            NUM_W'(6):  r = mk_rule(4,  1'b0, 3,    1'b1, 2);
            NUM_W'(7):  r = mk_rule(5,  1'b0, 2,    1'b1, 3);
            NUM_W'(8):  r = mk_rule(6,  1'b0, 255,  1'b0, 0);
            NUM_W'(11): r = mk_rule(7,  1'b0, 255,  1'b0, 0);
            NUM_W'(12): r = mk_rule(8,  1'b0, 2,    1'b1, 4);
            NUM_W'(14): r = mk_rule(9,  1'b0, 4,    1'b1, 5);
            NUM_W'(15): r = mk_rule(10, 1'b0, 255,  1'b0, 0);
            NUM_W'(17): r = mk_rule(11, 1'b0, 2,    1'b1, 6);
            NUM_W'(20): r = mk_rule(12, 1'b0, 255,  1'b0, 0);
            NUM_W'(35): r = mk_rule(13, 1'b1, 1034, 1'b1, 7);
            NUM_W'(39): r = mk_rule(14, 1'b1, 255,  1'b1, 8);
            NUM_W'(60): r = mk_rule(15, 1'b0, 4,    1'b1, 9);
            NUM_W'(28): r = mk_rule(16, 1'b0, 4,    1'b1, 10);
            NUM_W'(27): r = mk_rule(17, 1'b0, 3,    1'b1, 11);
            NUM_W'(23): r = mk_rule(18, 1'b0, 3,    1'b1, 12);
            default:    r = '0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/coc_if.sv]
interface coc_in_if;
    logic                       valid;
    logic                       ready;
    logic [coc_pkg::NUM_W-1:0]  option_number;
    logic [coc_pkg::LEN_W-1:0]  option_length;
    logic                       last_option;

    modport source (output valid, output option_number, output option_length,
                    output last_option, input ready);
    modport sink   (input valid, input option_number, input option_length,
                    input last_option, output ready);
    modport mon    (input valid, input ready, input option_number, input option_length,
                    input last_option);
endinterface

interface coc_out_if;
    logic                        valid;
    logic                        ready;
    logic [coc_pkg::ERR_W-1:0]   option_errors;
    logic [coc_pkg::ERR_W-1:0]   message_errors;
    logic [coc_pkg::PRES_W-1:0]  present_mask;
    logic                        message_done;

    modport source (output valid, output option_errors, output message_errors,
                    output present_mask, output message_done, input ready);
    modport sink   (input valid, input option_errors, input message_errors,
                    input present_mask, input message_done, output ready);
    modport mon    (input valid, input ready, input option_errors, input message_errors,
                    input present_mask, input message_done);
endinterface

interface coc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [coc_pkg::CFG_IDX_W-1:0]    index;
    logic [coc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
    modport mon    (input valid, input ready, input index, input data);
endinterface

[hw/rtl/coap_option_checker.sv]
// channel   | dir | payload                                               | handshake
// ----------+-----+-------------------------------------------------------+------------
// opt_in    | in  | option_number, option_length, last_option             | valid/ready
// res_out   | out | option_errors, message_errors, present_mask, done     | valid/ready
// cfg       | in  | index, data (register write)                          | valid/ready
//
// one word per cycle in and out while results are taken; a result is offered once its word has passed
// the input register, then table lookup and mask update into the result register
// rst_n clears the message state and presence mask and restores the version numbers
// a stalled result register holds its word; the input register takes one more word,
// then opt_in.ready drops until the result drains
// cfg is always ready; the user writes it only while no word is in flight, the block does not enforce this
module coap_option_checker
(
    input  logic          clk,
    input  logic          rst_n,
    coc_in_if.sink        opt_in,
    coc_out_if.source     res_out,
    coc_cfg_if.sink       cfg
);

    // input register
    logic                         s1_valid_reg, s1_valid_next;
    logic [coc_pkg::NUM_W-1:0]    s1_number_reg;
    logic [coc_pkg::LEN_W-1:0]    s1_length_reg;
    logic                         s1_last_reg;

    // configuration
    logic [coc_pkg::NUM_W-1:0]    content_num_reg, content_num_next;
    logic [coc_pkg::NUM_W-1:0]    accept_num_reg, accept_num_next;

    // message and presence state
    logic [coc_pkg::SINGLE_W-1:0] single_seen_reg, single_seen_next;
    logic [coc_pkg::ERR_W-1:0]    error_accum_reg, error_accum_next;
    logic [coc_pkg::PRES_W-1:0]   presence_reg, presence_next;

    // result register
    logic                         out_valid_reg, out_valid_next;
    logic [coc_pkg::ERR_W-1:0]    out_errors_reg;
    logic [coc_pkg::ERR_W-1:0]    out_msg_reg;
    logic [coc_pkg::PRES_W-1:0]   out_pres_reg;
    logic                         out_done_reg;

    logic                         advance;
    logic                         in_take;
    logic                         fire;
    coc_pkg::rule_t               rule;
    logic                         critical;
    logic                         len_bad;
    logic                         seen_hit;
    logic [coc_pkg::ERR_W-1:0]    errs;
    logic [coc_pkg::ERR_W-1:0]    acc;
    logic [coc_pkg::PRES_W-1:0]   pres_set;
    logic [coc_pkg::SINGLE_W-1:0] single_set;

    // result register moves on when empty or drained this cycle
    assign advance      = !out_valid_reg || res_out.ready;
    assign opt_in.ready = !s1_valid_reg || advance;
    assign in_take      = opt_in.valid && opt_in.ready;
    assign fire         = s1_valid_reg && advance;
    assign cfg.ready    = 1'b1;

    // lookup and checks on the registered word
    always_comb
    begin
        rule       = coc_pkg::lookup_rule(s1_number_reg);
        critical   = s1_number_reg[0];
        len_bad    = (rule.len_min_one && (s1_length_reg == '0))
                     || ({{(coc_pkg::LEN_W-coc_pkg::LEN_MAX_W){1'b0}}, rule.len_max}
                         < s1_length_reg);
        seen_hit   = rule.single && single_seen_reg[rule.single_idx];
        errs       = '0;
        pres_set   = '0;
        single_set = '0;
        // fixed table first, then the two programmable numbers, content before accept
        priority if (rule.found)
        begin
            pres_set[rule.pres_idx] = 1'b1;
            if (len_bad)
            begin
                errs[coc_pkg::ERR_LEN_CRIT] = critical;
                errs[coc_pkg::ERR_LEN]      = !critical;
            end
            if (seen_hit)
            begin
                errs[coc_pkg::ERR_REPEAT_CRIT] = critical;
                errs[coc_pkg::ERR_REPEAT]      = !critical;
            end
            else if (rule.single)
            begin
                single_set[rule.single_idx] = 1'b1;
            end
        end
        else if (s1_number_reg == content_num_reg)
        begin
            pres_set[coc_pkg::PRES_CONTENT_VERSION] = 1'b1;
        end
        else if (s1_number_reg == accept_num_reg)
        begin
            pres_set[coc_pkg::PRES_ACCEPT_VERSION] = 1'b1;
        end
        else
        begin
            errs[coc_pkg::ERR_UNKNOWN_CRIT] = critical;
            errs[coc_pkg::ERR_UNKNOWN]      = !critical;
        end
        acc = error_accum_reg | errs;
    end

    // next state
    always_comb
    begin
        s1_valid_next    = s1_valid_reg;
        out_valid_next   = out_valid_reg;
        single_seen_next = single_seen_reg;
        error_accum_next = error_accum_reg;
        presence_next    = presence_reg;
        content_num_next = content_num_reg;
        accept_num_next  = accept_num_reg;

        if (opt_in.ready)
        begin
            s1_valid_next = opt_in.valid;
        end
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (fire)
        begin
            presence_next = presence_reg | pres_set;
            // message state restarts after the last option
            if (s1_last_reg)
            begin
                single_seen_next = '0;
                error_accum_next = '0;
            end
            else
            begin
                single_seen_next = single_seen_reg | single_set;
                error_accum_next = acc;
            end
        end
        if (cfg.valid)
        begin
            // writes to other indexes are dropped
            if (cfg.index == coc_pkg::CFG_CONTENT_VERSION)
            begin
                content_num_next = cfg.data;
            end
            else if (cfg.index == coc_pkg::CFG_ACCEPT_VERSION)
            begin
                accept_num_next = cfg.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            single_seen_reg <= '0;
            error_accum_reg <= '0;
            presence_reg    <= '0;
            content_num_reg <= coc_pkg::NUM_W'(coc_pkg::CFG_CONTENT_RESET);
            accept_num_reg  <= coc_pkg::NUM_W'(coc_pkg::CFG_ACCEPT_RESET);
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            single_seen_reg <= single_seen_next;
            error_accum_reg <= error_accum_next;
            presence_reg    <= presence_next;
            content_num_reg <= content_num_next;
            accept_num_reg  <= accept_num_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_number_reg <= opt_in.option_number;
            s1_length_reg <= opt_in.option_length;
            s1_last_reg   <= opt_in.last_option;
        end
        if (fire)
        begin
            out_errors_reg <= errs;
            out_msg_reg    <= acc;
            out_pres_reg   <= presence_reg | pres_set;
            out_done_reg   <= s1_last_reg;
        end
    end

    assign res_out.valid          = out_valid_reg;
    assign res_out.option_errors  = out_errors_reg;
    assign res_out.message_errors = out_msg_reg;
    assign res_out.present_mask   = out_pres_reg;
    assign res_out.message_done   = out_done_reg;

endmodule

[hw/rtl/coc_checker.sv]
module coc_checker
(
    input  logic        clk,
    input  logic        rst_n,
    coc_in_if.sink      opt_in,
    coc_out_if.source   res_out,
    coc_cfg_if.sink     cfg
);

    // stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.ready |=> res_out.valid)
        else $error("result dropped while stalled");

    // stalled result holds its word
    assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.ready |=>
            $stable(res_out.option_errors) && $stable(res_out.message_errors)
            && $stable(res_out.present_mask) && $stable(res_out.message_done))
        else $error("result word changed while stalled");

    // running message mask always covers this word's errors
    assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid |-> (res_out.option_errors & ~res_out.message_errors) == '0)
        else $error("message errors miss an option error");

    // never critical and elective at once; unknown stands alone
    assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid |->
            $countones(res_out.option_errors[coc_pkg::ERR_UNKNOWN_CRIT:coc_pkg::ERR_UNKNOWN])
                <= 1
            && !(res_out.option_errors[coc_pkg::ERR_LEN]
                 && res_out.option_errors[coc_pkg::ERR_LEN_CRIT])
            && !(res_out.option_errors[coc_pkg::ERR_REPEAT]
                 && res_out.option_errors[coc_pkg::ERR_REPEAT_CRIT])
            && !((res_out.option_errors[coc_pkg::ERR_UNKNOWN]
                  || res_out.option_errors[coc_pkg::ERR_UNKNOWN_CRIT])
                 && (res_out.option_errors[coc_pkg::ERR_REPEAT_CRIT:coc_pkg::ERR_LEN] != '0)))
        else $error("inconsistent option error bits");

    // presence bits never fall between consecutive results
    assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.ready |=>
            !res_out.valid
            || ((res_out.present_mask & $past(res_out.present_mask))
                == $past(res_out.present_mask)))
        else $error("presence bit lost");

endmodule

bind coap_option_checker coc_checker u_coc_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .opt_in  (opt_in),
    .res_out (res_out),
    .cfg     (cfg)
);

[verif/testbench.sv]
module testbench;

    // run length and pacing
    localparam int WORD_TARGET = 1950;
    localparam int IDLE_PCT    = 30;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;
    localparam int NUM_RULES   = 19;

    // fixed option table; position in the table is also the presence bit
    localparam int OPT_NUM [0:NUM_RULES-1] =
        '{1, 3, 4, 5, 6, 7, 8, 11, 12, 14, 15, 17, 20, 35, 39, 60, 28, 27, 23};
    localparam int LEN_LO  [0:NUM_RULES-1] =
        '{0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0};
    localparam int LEN_HI  [0:NUM_RULES-1] =
        '{8, 255, 8, 0, 3, 2, 255, 255, 2, 4, 255, 2, 255, 1034, 255, 4, 4, 3, 3};
    // slot in the repeat mask, -1 where the option may appear many times
    localparam int ONCE_SLOT [0:NUM_RULES-1] =
        '{-1, 0, -1, 1, 2, 3, -1, -1, 4, 5, -1, 6, -1, 7, 8, 9, 10, 11, 12};

    typedef struct packed {
        logic [coc_pkg::NUM_W-1:0] num;
        logic [coc_pkg::LEN_W-1:0] len;
        logic                      last;
    } option_word_t;

    typedef struct packed {
        logic [coc_pkg::ERR_W-1:0]  opt_errs;
        logic [coc_pkg::ERR_W-1:0]  msg_errs;
        logic [coc_pkg::PRES_W-1:0] present;
        logic                       done;
    } option_verdict_t;

    logic clk;
    logic rst_n;

    coc_in_if  opt_in_bus ();
    coc_out_if res_out_bus ();
    coc_cfg_if cfg_bus ();

    coap_option_checker u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .opt_in  (opt_in_bus),
        .res_out (res_out_bus),
        .cfg     (cfg_bus)
    );

    // predictor state, mirrors what the checker should hold
    logic [coc_pkg::NUM_W-1:0]    content_ver;
    logic [coc_pkg::NUM_W-1:0]    accept_ver;
    logic [coc_pkg::SINGLE_W-1:0] seen_once;
    logic [coc_pkg::ERR_W-1:0]    msg_errs_run;
    logic [coc_pkg::PRES_W-1:0]   present_bits;

    option_verdict_t pending_verdicts [$];

    // bookkeeping
    int  fail_count;
    int  words_sent;
    int  messages_seen;
    int  results_checked;
    int  reg_writes;
    int  err_hits [coc_pkg::ERR_W];
    int  cycle_count;
    bit  calm;           // no idling on either side while set
    bit  hold_request;   // receiver clears it and holds ready low once picked up

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, pending_verdicts.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // table position of a fixed option, -1 when the number is not in the table
    function automatic int rule_slot(input logic [coc_pkg::NUM_W-1:0] num);
        for (int i = 0; i < NUM_RULES; i++)
        begin
            if (num == coc_pkg::NUM_W'(OPT_NUM[i]))
                return i;
        end
        return -1;
    endfunction

    // works out the result word of one accepted option and advances the state
    function automatic option_verdict_t predict_option(input option_word_t w);
        option_verdict_t           v;
        logic [coc_pkg::ERR_W-1:0] errs;
        int                        slot;
        bit                        crit;
        errs = '0;
        crit = w.num[0];
        slot = rule_slot(w.num);
        if (slot >= 0)
        begin
            present_bits[slot] = 1'b1;
            if (int'(w.len) < LEN_LO[slot] || int'(w.len) > LEN_HI[slot])
                errs[crit ? coc_pkg::ERR_LEN_CRIT : coc_pkg::ERR_LEN] = 1'b1;
            if (ONCE_SLOT[slot] >= 0)
            begin
                if (seen_once[ONCE_SLOT[slot]])
                    errs[crit ? coc_pkg::ERR_REPEAT_CRIT : coc_pkg::ERR_REPEAT] = 1'b1;
                else
                    seen_once[ONCE_SLOT[slot]] = 1'b1;
            end
        end
        // fixed options shadow the programmable ones, content before accept
        else if (w.num == content_ver)
            present_bits[coc_pkg::PRES_CONTENT_VERSION] = 1'b1;
        else if (w.num == accept_ver)
            present_bits[coc_pkg::PRES_ACCEPT_VERSION] = 1'b1;
        else
            errs[crit ? coc_pkg::ERR_UNKNOWN_CRIT : coc_pkg::ERR_UNKNOWN] = 1'b1;

        msg_errs_run = msg_errs_run | errs;
        for (int b = 0; b < coc_pkg::ERR_W; b++)
            err_hits[b] += errs[b];

        v.opt_errs = errs;
        v.msg_errs = msg_errs_run;
        v.present  = present_bits;
        v.done     = w.last;
        if (w.last)
        begin
            seen_once    = '0;
            msg_errs_run = '0;
        end
        return v;
    endfunction

    // one process watches all three channels at the rising edge:
    // results are checked first, then register writes and new words are taken in
    always @(posedge clk)
    begin : watch_channels
        option_verdict_t want;
        option_word_t    w;
        if (rst_n)
        begin
            if (res_out_bus.valid && res_out_bus.ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    results_checked++;
                    if (res_out_bus.option_errors !== want.opt_errs)
                    begin
                        $error("option_errors: expected %0h, got %0h",
                               want.opt_errs, res_out_bus.option_errors);
                        fail_count++;
                    end
                    if (res_out_bus.message_errors !== want.msg_errs)
                    begin
                        $error("message_errors: expected %0h, got %0h",
                               want.msg_errs, res_out_bus.message_errors);
                        fail_count++;
                    end
                    if (res_out_bus.present_mask !== want.present)
                    begin
                        $error("present_mask: expected %0h, got %0h",
                               want.present, res_out_bus.present_mask);
                        fail_count++;
                    end
                    if (res_out_bus.message_done !== want.done)
                    begin
                        $error("message_done: expected %0h, got %0h",
                               want.done, res_out_bus.message_done);
                        fail_count++;
                    end
                end
            end
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                // indexes past the register list are dropped
                if (cfg_bus.index == coc_pkg::CFG_CONTENT_VERSION)
                    content_ver = cfg_bus.data;
                else if (cfg_bus.index == coc_pkg::CFG_ACCEPT_VERSION)
                    accept_ver = cfg_bus.data;
                reg_writes++;
            end
            if (opt_in_bus.valid && opt_in_bus.ready)
            begin
                w.num  = opt_in_bus.option_number;
                w.len  = opt_in_bus.option_length;
                w.last = opt_in_bus.last_option;
                pending_verdicts.push_back(predict_option(w));
                words_sent++;
                if (w.last)
                    messages_seen++;
            end
        end
    end

    // receiver: random stalls, a calm mode, and one long hold-off on request
    initial
    begin
        res_out_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                res_out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                res_out_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // sends one word; called and returns at a falling edge, valid left high so
    // that back-to-back words need no second assignment in the same step
    task automatic send_option(input logic [coc_pkg::NUM_W-1:0] num,
                               input logic [coc_pkg::LEN_W-1:0] len,
                               input logic last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            opt_in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        opt_in_bus.valid         <= 1'b1;
        opt_in_bus.option_number <= num;
        opt_in_bus.option_length <= len;
        opt_in_bus.last_option   <= last;
        do
            @(posedge clk);
        while (!opt_in_bus.ready);
        @(negedge clk);
    endtask

    // stop offering words and wait for every outstanding result
    task automatic wait_for_results();
        opt_in_bus.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // register write, only ever issued with the checker empty
    task automatic write_reg(input logic [coc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [coc_pkg::CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_versions(input logic [coc_pkg::NUM_W-1:0] c,
                                input logic [coc_pkg::NUM_W-1:0] a);
        wait_for_results();
        write_reg(coc_pkg::CFG_CONTENT_VERSION, c);
        write_reg(coc_pkg::CFG_ACCEPT_VERSION, a);
    endtask

    // biased option number: some repeats of the previous one, mostly table entries, then versions, then strays
    function automatic logic [coc_pkg::NUM_W-1:0] pick_number(
        input logic [coc_pkg::NUM_W-1:0] prev, input bit first);
        int r;
        r = $urandom_range(0, 99);
        if (!first && r < 12)
            return prev;              // deliberate repeat
        else if (r < 70)
            return coc_pkg::NUM_W'(OPT_NUM[$urandom_range(0, NUM_RULES - 1)]);
        else if (r < 80)
            return content_ver;
        else if (r < 88)
            return accept_ver;
        else if (r < 94)
            return coc_pkg::NUM_W'($urandom_range(0, 63));
        else
            return coc_pkg::NUM_W'($urandom);
    endfunction

    // lengths cluster on the bounds of the option's legal range
    function automatic logic [coc_pkg::LEN_W-1:0] pick_length(
        input logic [coc_pkg::NUM_W-1:0] num);
        int slot;
        slot = rule_slot(num);
        if (slot < 0)
            return ($urandom_range(0, 1) == 0) ? coc_pkg::LEN_W'($urandom_range(0, 16))
                                               : coc_pkg::LEN_W'($urandom);
        case ($urandom_range(0, 9))
            0:       return coc_pkg::LEN_W'((LEN_LO[slot] > 0) ? LEN_LO[slot] - 1
                                                               : LEN_HI[slot] + 1);
            1:       return coc_pkg::LEN_W'(LEN_LO[slot]);
            2:       return coc_pkg::LEN_W'(LEN_HI[slot]);
            3:       return coc_pkg::LEN_W'(LEN_HI[slot] + 1);
            4:       return {coc_pkg::LEN_W{1'b1}};
            5:       return coc_pkg::LEN_W'($urandom);
            default: return coc_pkg::LEN_W'($urandom_range(LEN_LO[slot], LEN_HI[slot]));
        endcase
    endfunction

    task automatic send_random_message(input int max_opts);
        int                        n;
        logic [coc_pkg::NUM_W-1:0] num;
        n   = $urandom_range(1, max_opts);
        num = '0;
        for (int i = 0; i < n; i++)
        begin
            num = pick_number(num, i == 0);
            send_option(num, pick_length(num), i == n - 1);
        end
    endtask

    // every table option once at its upper bound, then strays, versions, a length
    // below minimum, the critical length plus repeat case and an elective length error
    task automatic test_reset_defaults();
        for (int i = 0; i < NUM_RULES; i++)
            send_option(coc_pkg::NUM_W'(OPT_NUM[i]), coc_pkg::LEN_W'(LEN_HI[i]),
                        i == NUM_RULES - 1);
        send_option('0, '0, 1'b0);                                      // unknown, elective
        send_option({coc_pkg::NUM_W{1'b1}}, {coc_pkg::LEN_W{1'b1}}, 1'b0); // unknown, critical
        send_option(coc_pkg::NUM_W'(coc_pkg::CFG_CONTENT_RESET),
                    {coc_pkg::LEN_W{1'b1}}, 1'b0);                      // no length check
        send_option(coc_pkg::NUM_W'(coc_pkg::CFG_ACCEPT_RESET), '0, 1'b0);
        send_option(coc_pkg::NUM_W'(coc_pkg::CFG_ACCEPT_RESET), '0, 1'b0); // no repeat check
        send_option(coc_pkg::NUM_W'(35), '0, 1'b0);                     // below minimum
        send_option(coc_pkg::NUM_W'(35), coc_pkg::LEN_W'(1035), 1'b0);  // length and repeat
        send_option(coc_pkg::NUM_W'(4), coc_pkg::LEN_W'(9), 1'b1);      // elective length
        wait_for_results();
    endtask

    // version registers at extremes, aliased onto fixed options and onto each other
    task automatic try_versions(input logic [coc_pkg::NUM_W-1:0] c,
                                input logic [coc_pkg::NUM_W-1:0] a);
        set_versions(c, a);
        send_option(c, {coc_pkg::LEN_W{1'b1}}, 1'b0);
        send_option(a, '0, 1'b0);
        send_option(c, coc_pkg::LEN_W'($urandom), 1'b0);
        send_option(a, coc_pkg::LEN_W'($urandom), 1'b1);
        repeat (6) send_random_message(8);
    endtask

    task automatic test_version_registers();
        try_versions('0, {coc_pkg::NUM_W{1'b1}});
        try_versions(coc_pkg::NUM_W'(3), coc_pkg::NUM_W'(35));       // fixed table takes priority
        try_versions(coc_pkg::NUM_W'(4000), coc_pkg::NUM_W'(4000));  // content wins the tie
        try_versions({coc_pkg::NUM_W{1'b1}}, '0);
        wait_for_results();
        // writes past the register list must leave both versions alone
        for (int k = int'(coc_pkg::CFG_ACCEPT_VERSION) + 1; k < (1 << coc_pkg::CFG_IDX_W); k++)
            write_reg(coc_pkg::CFG_IDX_W'(k), coc_pkg::CFG_DATA_W'($urandom));
        send_option({coc_pkg::NUM_W{1'b1}}, '0, 1'b0);
        send_option('0, '0, 1'b1);
        try_versions(coc_pkg::NUM_W'(coc_pkg::CFG_CONTENT_RESET),
                     coc_pkg::NUM_W'(coc_pkg::CFG_ACCEPT_RESET));
        wait_for_results();
    endtask

    // receiver stalls for a long stretch while the sender keeps offering words,
    // then the sender waits for the checker to empty out
    task automatic test_backpressure();
        calm = 1'b1;
        hold_request = 1'b1;
        repeat (4) send_random_message(10);
        wait_for_results();
        calm = 1'b0;
        hold_request = 1'b1;
        repeat (4) send_random_message(10);
        wait_for_results();
    endtask

    // bulk traffic; the opening stretch runs flat out, and the version
    // registers move every few hundred words
    task automatic test_random_messages();
        int next_reconfig;
        next_reconfig = words_sent + 400;
        calm = 1'b1;
        while (words_sent < WORD_TARGET)
        begin
            if (calm && words_sent > 600)
                calm = 1'b0;
            if (words_sent >= next_reconfig)
            begin
                next_reconfig = words_sent + 400;
                case ($urandom_range(0, 5))
                    0: set_versions('0, {coc_pkg::NUM_W{1'b1}});
                    1: set_versions({coc_pkg::NUM_W{1'b1}}, '0);
                    2: set_versions(coc_pkg::NUM_W'($urandom_range(0, 63)),
                                    coc_pkg::NUM_W'($urandom_range(0, 63)));
                    3: set_versions(coc_pkg::NUM_W'(OPT_NUM[$urandom_range(0, NUM_RULES - 1)]),
                                    coc_pkg::NUM_W'($urandom));
                    4: set_versions(coc_pkg::NUM_W'(coc_pkg::CFG_CONTENT_RESET),
                                    coc_pkg::NUM_W'(coc_pkg::CFG_ACCEPT_RESET));
                    default: set_versions(coc_pkg::NUM_W'($urandom), coc_pkg::NUM_W'($urandom));
                endcase
            end
            send_random_message(($urandom_range(0, 9) == 0) ? 20 : 8);
        end
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        opt_in_bus.valid         = 1'b0;
        opt_in_bus.option_number = '0;
        opt_in_bus.option_length = '0;
        opt_in_bus.last_option   = 1'b0;
        cfg_bus.valid            = 1'b0;
        cfg_bus.index            = '0;
        cfg_bus.data             = '0;
        calm                     = 1'b0;
        hold_request             = 1'b0;
        content_ver              = coc_pkg::NUM_W'(coc_pkg::CFG_CONTENT_RESET);
        accept_ver               = coc_pkg::NUM_W'(coc_pkg::CFG_ACCEPT_RESET);
        seen_once                = '0;
        msg_errs_run             = '0;
        present_bits             = '0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_version_registers();
        test_backpressure();
        test_random_messages();

        wait_for_results();
        repeat (SETTLE) @(posedge clk);
        if (pending_verdicts.size() != 0)
        begin
            $error("%0d results never arrived", pending_verdicts.size());
            fail_count++;
        end

        $display("checked %0d result words from %0d option words in %0d messages",
                 results_checked, words_sent, messages_seen);
        $display("%0d register writes; errors exercised (elective/critical): %s",
                 reg_writes, "see next line");
        $display("len %0d/%0d repeat %0d/%0d unknown %0d/%0d",
                 err_hits[coc_pkg::ERR_LEN], err_hits[coc_pkg::ERR_LEN_CRIT],
                 err_hits[coc_pkg::ERR_REPEAT], err_hits[coc_pkg::ERR_REPEAT_CRIT],
                 err_hits[coc_pkg::ERR_UNKNOWN], err_hits[coc_pkg::ERR_UNKNOWN_CRIT]);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
